### hw/rtl/tdta_pkg.sv
`default_nettype none

package tdta_pkg;

  // Field widths of one item.
  localparam int ID_W   = 10;
  localparam int TICK_W = 16;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;
  localparam int RUN_W  = 3;

  // Action codes of an input item.
  localparam logic [ACT_W-1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_GRANT   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

  // Status codes of a result item.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_BUSY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  // Direction history codes.
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_WEST = 2'd1;
  localparam logic [1:0] DIR_EAST = 2'd2;

  // Run counter saturation and register reset value.
  localparam logic [RUN_W-1:0] RUN_MAX        = 3'd7;
  localparam logic [RUN_W-1:0] MAX_SAME_RESET = 3'd2;

  // One stored requester.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              high;
    logic [TICK_W-1:0] tick;
  } entry_t;

  // One queue slot as kept in memory.
  typedef struct packed {
    logic   valid;
    entry_t ent;
  } slot_t;

  // Control of the shared pick unit.
  typedef struct packed {
    logic start;
    logic en;
    logic find_free;
    logic only_high;
  } pick_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/tdta_in_if.sv
`default_nettype none

interface tdta_in_if;
  import tdta_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [ID_W-1:0]     requester_id;
  logic                goes_east;
  logic                high_priority;
  logic [TICK_W-1:0]   ready_tick;

  modport source (
    output valid, action, requester_id, goes_east, high_priority, ready_tick,
    input  ready
  );

  modport sink (
    input  valid, action, requester_id, goes_east, high_priority, ready_tick,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/tdta_out_if.sv
`default_nettype none

interface tdta_out_if;
  import tdta_pkg::*;

  logic              valid;
  logic              ready;
  logic              granted;
  logic [ID_W-1:0]   granted_id;
  logic              granted_east;
  logic [STAT_W-1:0] status;

  modport source (
    output valid, granted, granted_id, granted_east, status,
    input  ready
  );

  modport sink (
    input  valid, granted, granted_id, granted_east, status,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/two_direction_track_arbiter_unit.sv
// Arbiter for one shared resource fed by an east and a west queue of
// QUEUE_DEPTH requesters each. Items arrive on cmd: enqueue, grant or
// release; every item gives exactly one item on result. Enqueue and grant
// items run scan, drain and commit steps, since one comparator walks all slots
// of one queue memory at one read per cycle (free-slot search for enqueue,
// best-candidate search for grant). Release items and items answered at once
// (busy, both queues empty, queue full, unused action) go straight to report.
// After reset a clearing pass over all slots runs before the first item is
// taken; the configuration register may be written at any time while idle.
// A finished result waits in the output register while the next item starts.

`default_nettype none

module two_direction_track_arbiter_unit #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [tdta_pkg::RUN_W-1:0]    cfg_wr_data,
  tdta_in_if.sink                       cmd,
  tdta_out_if.source                    result
);
  import tdta_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_DRAIN, S_COMMIT, S_REPORT
  } state_t;

  state_t state;

  // Sequencer and item registers.
  logic [AW-1:0]     addr_cnt;
  logic              pend;
  logic [AW-1:0]     pend_slot;
  logic [ACT_W-1:0]  act_q;
  logic [ID_W-1:0]   id_q;
  logic              high_q;
  logic [TICK_W-1:0] tick_q;
  logic              east_q;
  logic              only_high_q;

  // Arbiter state.
  logic [CW-1:0]     cnt_e;
  logic [CW-1:0]     cnt_w;
  logic [CW-1:0]     hcnt_e;
  logic [CW-1:0]     hcnt_w;
  logic              busy;
  logic [1:0]        prev_dir;
  logic [RUN_W-1:0]  run;
  logic [RUN_W-1:0]  max_same;

  // Pending result.
  logic              res_granted;
  logic [ID_W-1:0]   res_id;
  logic              res_east;
  logic [STAT_W-1:0] res_status;

  // Memories.
  slot_t             mem_e [QUEUE_DEPTH];
  slot_t             mem_w [QUEUE_DEPTH];
  slot_t             rd_e;
  slot_t             rd_w;
  logic              we_e;
  logic              we_w;
  logic [AW-1:0]     waddr;
  slot_t             wdata;

  // Pick unit connection.
  pick_ctrl_t        pick_ctrl;
  logic              pick_found;
  logic [AW-1:0]     pick_slot;
  entry_t            pick_ent;

  // Grant decision.
  logic              ev;
  logic              wv;
  logic              he;
  logic              hw;
  logic              opp_east;
  logic              forced;
  logic              req_high;
  logic              cand_e;
  logic              cand_w;
  logic              pick_east;
  logic              pick_high;
  logic [1:0]        new_dir;
  logic              accept;
  logic              out_free;

  assign accept   = cmd.valid && cmd.ready;
  assign out_free = !result.valid || result.ready;
  assign cmd.ready = (state == S_IDLE);

  // The direction and the priority filter of a grant follow from the counters
  // alone, so only the winning queue is scanned.
  assign ev       = (cnt_e != '0);
  assign wv       = (cnt_w != '0);
  assign he       = (hcnt_e != '0);
  assign hw       = (hcnt_w != '0);
  assign opp_east = (prev_dir == DIR_WEST);
  assign forced   = (prev_dir != DIR_NONE) && (run >= max_same) && (opp_east ? ev : wv);
  assign req_high = he || hw;
  assign cand_e   = req_high ? he : ev;
  assign cand_w   = req_high ? hw : wv;

  always_comb begin
    if (forced) begin
      pick_east = opp_east;
      pick_high = opp_east ? he : hw;
    end else begin
      pick_east = (cand_e && cand_w) ? opp_east : cand_e;
      pick_high = req_high;
    end
  end

  assign new_dir = east_q ? DIR_EAST : DIR_WEST;

  // Memory write port: clearing pass after reset, then commits.
  always_comb begin
    we_e  = 1'b0;
    we_w  = 1'b0;
    waddr = pick_slot;
    wdata = '0;
    if (state == S_CLEAR) begin
      we_e  = 1'b1;
      we_w  = 1'b1;
      waddr = addr_cnt;
    end else if (state == S_COMMIT) begin
      we_e = east_q;
      we_w = !east_q;
      if (act_q == ACT_ENQUEUE) begin
        wdata = '{valid: 1'b1, ent: '{id: id_q, high: high_q, tick: tick_q}};
      end
    end
  end

  // Queue memories with registered read data.
  always_ff @(posedge clk) begin
    if (we_e) begin
      mem_e[waddr] <= wdata;
    end
    rd_e <= mem_e[addr_cnt];
  end

  always_ff @(posedge clk) begin
    if (we_w) begin
      mem_w[waddr] <= wdata;
    end
    rd_w <= mem_w[addr_cnt];
  end

  // Shared compare unit.
  assign pick_ctrl = '{
    start:     accept,
    en:        pend,
    find_free: (act_q == ACT_ENQUEUE),
    only_high: only_high_q
  };

  tdta_pick_unit #(
    .SLOT_W (AW)
  ) u_pick (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (pick_ctrl),
    .word      (east_q ? rd_e : rd_w),
    .slot      (pend_slot),
    .found     (pick_found),
    .best_slot (pick_slot),
    .best_ent  (pick_ent)
  );

  // Item registers and the slot pipeline.
  always_ff @(posedge clk) begin
    pend_slot <= addr_cnt;
    if (accept) begin
      act_q  <= cmd.action;
      id_q   <= cmd.requester_id;
      high_q <= cmd.high_priority;
      tick_q <= cmd.ready_tick;
      if (cmd.action == ACT_GRANT) begin
        east_q      <= pick_east;
        only_high_q <= pick_high;
      end else begin
        east_q      <= cmd.goes_east;
        only_high_q <= 1'b0;
      end
    end
  end

  // Sequencer, arbiter state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      addr_cnt     <= '0;
      pend         <= 1'b0;
      cnt_e        <= '0;
      cnt_w        <= '0;
      hcnt_e       <= '0;
      hcnt_w       <= '0;
      busy         <= 1'b0;
      prev_dir     <= DIR_NONE;
      run          <= '0;
      max_same     <= MAX_SAME_RESET;
      result.valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_same <= cfg_wr_data;
      end
      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      pend <= (state == S_SCAN);

      unique case (state)
        S_CLEAR: begin
          if (addr_cnt == LAST_ADDR) begin
            addr_cnt <= '0;
            state    <= S_IDLE;
          end else begin
            addr_cnt <= addr_cnt + AW'(1);
          end
        end

        S_IDLE: begin
          if (cmd.valid) begin
            addr_cnt    <= '0;
            res_granted <= 1'b0;
            res_id      <= '0;
            res_east    <= 1'b0;
            res_status  <= ST_OK;
            state       <= S_REPORT;
            unique case (cmd.action)
              ACT_ENQUEUE: begin
                if ((cmd.goes_east ? cnt_e : cnt_w) == FULL_COUNT) begin
                  res_status <= ST_FULL;
                end else begin
                  state <= S_SCAN;
                end
              end
              ACT_GRANT: begin
                if (busy) begin
                  res_status <= ST_BUSY;
                end else if (!ev && !wv) begin
                  res_status <= ST_EMPTY;
                end else begin
                  state <= S_SCAN;
                end
              end
              ACT_RELEASE: begin
                busy <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end

        S_SCAN: begin
          if (addr_cnt == LAST_ADDR) begin
            addr_cnt <= '0;
            state    <= S_DRAIN;
          end else begin
            addr_cnt <= addr_cnt + AW'(1);
          end
        end

        S_DRAIN: begin
          state <= S_COMMIT;
        end

        S_COMMIT: begin
          if (act_q == ACT_ENQUEUE) begin
            if (east_q) begin
              cnt_e  <= cnt_e + CW'(1);
              hcnt_e <= hcnt_e + CW'(high_q);
            end else begin
              cnt_w  <= cnt_w + CW'(1);
              hcnt_w <= hcnt_w + CW'(high_q);
            end
          end else if (pick_found) begin
            if (east_q) begin
              cnt_e  <= cnt_e - CW'(1);
              hcnt_e <= hcnt_e - CW'(pick_ent.high);
            end else begin
              cnt_w  <= cnt_w - CW'(1);
              hcnt_w <= hcnt_w - CW'(pick_ent.high);
            end
            busy     <= 1'b1;
            prev_dir <= new_dir;
            if (new_dir == prev_dir) begin
              if (run != RUN_MAX) begin
                run <= run + RUN_W'(1);
              end
            end else begin
              run <= RUN_W'(1);
            end
            res_granted <= 1'b1;
            res_id      <= pick_ent.id;
            res_east    <= east_q;
          end else begin
            // No candidate in the chosen queue: report it as empty.
            res_status <= ST_EMPTY;
          end
          state <= S_REPORT;
        end

        S_REPORT: begin
          if (out_free) begin
            result.valid        <= 1'b1;
            result.granted      <= res_granted;
            result.granted_id   <= res_id;
            result.granted_east <= res_east;
            result.status       <= res_status;
            state               <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

`default_nettype wire

### hw/rtl/tdta_pick_unit.sv
`default_nettype none

module tdta_pick_unit #(
  parameter int SLOT_W = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tdta_pkg::pick_ctrl_t ctrl,
  input  tdta_pkg::slot_t      word,
  input  logic [SLOT_W-1:0]    slot,
  output logic                 found,
  output logic [SLOT_W-1:0]    best_slot,
  output tdta_pkg::entry_t     best_ent
);
  import tdta_pkg::*;

  logic cand;
  logic better;

  // A free search takes the first empty slot; a best search takes valid
  // entries that pass the priority filter.
  assign cand = ctrl.find_free ? !word.valid
                               : (word.valid && (!ctrl.only_high || word.ent.high));

  // Earliest tick wins, then the lower id. Slots arrive in ascending order,
  // so a strict compare keeps the lower slot on a full tie.
  assign better = !found ||
                  (!ctrl.find_free &&
                   ((word.ent.tick < best_ent.tick) ||
                    ((word.ent.tick == best_ent.tick) && (word.ent.id < best_ent.id))));

  // Running best over the scan.
  always_ff @(posedge clk) begin
    if (rst || ctrl.start) begin
      found <= 1'b0;
    end else if (ctrl.en && cand && better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en && cand && better) begin
      best_slot <= slot;
      best_ent  <= word.ent;
    end
  end
endmodule

`default_nettype wire

### hw/rtl/tdta_checker.sv
`default_nettype none

module tdta_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cmd_valid,
  input logic                          cmd_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic                          res_granted,
  input logic [tdta_pkg::ID_W-1:0]     res_granted_id,
  input logic                          res_granted_east,
  input logic [tdta_pkg::STAT_W-1:0]   res_status
);
  import tdta_pkg::*;

  // A result held back by the sink stays and keeps its payload.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_granted) &&
      $stable(res_granted_id) && $stable(res_granted_east) && $stable(res_status))
    else $error("result item changed while stalled");

  // A grant always reports success.
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_granted |-> res_status == ST_OK)
    else $error("granted result with non-ok status");

  // Results without a grant carry no requester.
  a_no_grant_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_granted |-> res_granted_id == '0 && !res_granted_east)
    else $error("non-grant result carries requester fields");

  // One item is worked on at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("item taken while another is in work");
endmodule

bind two_direction_track_arbiter_unit tdta_checker u_tdta_checker (
  .clk              (clk),
  .rst              (rst),
  .cmd_valid        (cmd.valid),
  .cmd_ready        (cmd.ready),
  .res_valid        (result.valid),
  .res_ready        (result.ready),
  .res_granted      (result.granted),
  .res_granted_id   (result.granted_id),
  .res_granted_east (result.granted_east),
  .res_status       (result.status)
);

`default_nettype wire
